FILE: hdl/sfuf_pkg.sv
// ============================================================================
// sfuf_pkg - shared types and constants for the spanning forest block
// Beat formats, controller/datapath command and status groups, store sizes.
// ============================================================================
package sfuf_pkg;

    // Vertex store geometry
    localparam int VERTEX_COUNT = 256;
    localparam int VERTEX_W     = $clog2(VERTEX_COUNT);

    // Forest edge counter saturates here
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Item opcodes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // Input beat
    typedef struct packed {
        logic       opcode;
        logic [7:0] vertex_a;
        logic [7:0] vertex_b;
    } t_sfuf_in;

    // Result beat
    typedef struct packed {
        logic       accepted;
        logic [7:0] tree_edge_count;
        logic [8:0] edge_first;
        logic [8:0] edge_second;
    } t_sfuf_out;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input beat, start search at vertex_a or clear
        logic walk;     // follow one parent link
        logic start_b;  // save root of a, start search at vertex_b
        logic finish;   // root of b found: merge if roots differ, build result
        logic emit;     // move result into output register
    } t_sfuf_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_clear; // pending input beat is a clear
        logic root_hit;   // current vertex is its own parent
    } t_sfuf_sts;

endpackage

FILE: hdl/sfuf_datapath.sv
// ============================================================================
// sfuf_datapath - parent store, root walker and result registers
// Holds the union-find parent memory with per-entry valid bits, walks parent
// links one per cycle, merges sets and keeps the forest edge count.
// ============================================================================
module sfuf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfuf_pkg::t_sfuf_cmd i_cmd,
    input  sfuf_pkg::t_sfuf_in  i_in_data,
    output sfuf_pkg::t_sfuf_sts o_sts,
    output sfuf_pkg::t_sfuf_out o_out_data
);

    localparam int VW = sfuf_pkg::VERTEX_W;

    // Parent memory; an entry without its valid bit is its own parent
    logic [VW-1:0]                     r_mem [sfuf_pkg::VERTEX_COUNT];
    logic [sfuf_pkg::VERTEX_COUNT-1:0] r_valid;
    logic [VW-1:0]                     r_rd_data;
    logic                              r_rd_valid;

    // Item and walk registers
    logic [VW-1:0]       r_a;
    logic [VW-1:0]       r_b;
    logic [VW-1:0]       r_cur;
    logic [VW-1:0]       r_root_a;
    logic [7:0]          r_count;
    sfuf_pkg::t_sfuf_out r_res;
    sfuf_pkg::t_sfuf_out r_out_data;

    logic [VW-1:0] eff_parent;
    logic [VW-1:0] rd_addr;
    logic          is_clear;
    logic          roots_differ;
    logic          merge;
    logic [7:0]    n_count;

    assign is_clear     = (i_in_data.opcode == sfuf_pkg::OP_CLEAR);
    assign eff_parent   = r_rd_valid ? r_rd_data : r_cur;
    assign roots_differ = (r_cur != r_root_a);
    assign merge        = i_cmd.finish && roots_differ;
    assign n_count      = (r_count != sfuf_pkg::COUNT_MAX) ? r_count + 8'd1 : r_count;

    assign o_sts.item_clear = is_clear;
    assign o_sts.root_hit   = (eff_parent == r_cur);
    assign o_out_data       = r_out_data;

    // Read address: start vertex or next link
    always_comb begin
        rd_addr = r_cur;
        if (i_cmd.accept) begin
            rd_addr = i_in_data.vertex_a[VW-1:0];
        end else if (i_cmd.start_b) begin
            rd_addr = r_b;
        end else if (i_cmd.walk) begin
            rd_addr = eff_parent;
        end
    end

    // Parent memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (merge) begin
            r_mem[r_root_a] <= r_cur;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Valid bits: cleared by reset or a clear beat, set on merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[rd_addr];
            if (i_cmd.accept && is_clear) begin
                r_valid <= '0;
            end else if (merge) begin
                r_valid[r_root_a] <= 1'b1;
            end
        end
    end

    // Forest edge count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && is_clear) begin
            r_count <= '0;
        end else if (merge) begin
            r_count <= n_count;
        end
    end

    // Walk state and result build
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a   <= i_in_data.vertex_a[VW-1:0];
            r_b   <= i_in_data.vertex_b[VW-1:0];
            r_cur <= i_in_data.vertex_a[VW-1:0];
            if (is_clear) begin
                r_res <= '0;
            end
        end else if (i_cmd.walk) begin
            r_cur <= eff_parent;
        end else if (i_cmd.start_b) begin
            r_root_a <= r_cur;
            r_cur    <= r_b;
        end else if (i_cmd.finish) begin
            r_res.accepted        <= roots_differ;
            r_res.tree_edge_count <= roots_differ ? n_count : r_count;
            r_res.edge_first      <= {1'b0, r_a} + 9'd1;
            r_res.edge_second     <= {1'b0, r_b} + 9'd1;
        end
        if (i_cmd.emit) begin
            r_out_data <= r_res;
        end
    end

endmodule

FILE: hdl/sfuf_ctrl.sv
// ============================================================================
// sfuf_ctrl - sequencer for the spanning forest block
// Accepts beats, steps the two root searches, and owns the output valid.
// ============================================================================
module sfuf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  sfuf_pkg::t_sfuf_sts i_sts,
    output sfuf_pkg::t_sfuf_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.item_clear ? S_DONE : S_WALK_A;
                end
            end
            S_WALK_A: begin
                if (i_sts.root_hit) begin
                    o_cmd.start_b = 1'b1;
                    n_state       = S_WALK_B;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_WALK_B: begin
                if (i_sts.root_hit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Output slot: filled on emit, drained when not stalled
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/spanning_forest_union_find.sv
// ============================================================================
// spanning_forest_union_find - union-find spanning forest builder
// Each beat clears the store or offers one edge; one result beat per item.
// ============================================================================
// A clear beat goes from acceptance straight to the done state. An edge beat
// first walks depth_a and then depth_b parent links, where depth_x is the number
// of links from that endpoint up to its set root: the root searches follow one
// link a cycle through the single read port of the parent memory. No clearing pass
// is needed after reset or a clear; per-entry valid bits restore the
// singleton sets at once. A new beat may be accepted while the previous result
// still waits in the output register.
module spanning_forest_union_find (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sfuf_pkg::t_sfuf_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sfuf_pkg::t_sfuf_out o_out_data
);

    sfuf_pkg::t_sfuf_cmd cmd;
    sfuf_pkg::t_sfuf_sts sts;

    // Sequencer
    sfuf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Parent store and result path
    sfuf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

FILE: hdl/sfuf_checker.sv
// ============================================================================
// sfuf_checker - port-level checks for the spanning forest block
// Watches the result channel for handshake and result consistency.
// ============================================================================
module sfuf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sfuf_pkg::t_sfuf_out o_out_data
);

    // Stalled result beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // Stalled result beat keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // An accepted edge always leaves a nonzero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |-> o_out_data.tree_edge_count != 8'd0)
        else $error("accepted edge with zero forest count");

    // Self-loops never enter the forest
    a_no_self_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |->
            o_out_data.edge_first != o_out_data.edge_second)
        else $error("self-loop accepted");

    // Clear result is all zero
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.edge_first == 9'd0 |->
            !o_out_data.accepted && o_out_data.tree_edge_count == 8'd0
            && o_out_data.edge_second == 9'd0)
        else $error("clear result not zero");

endmodule

bind spanning_forest_union_find sfuf_checker u_sfuf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
